// ----- hw/rtl/go_back_n_sender_window_assert.svh -----
// Assertion macros for the Go-Back-N sender window.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef GO_BACK_N_SENDER_WINDOW_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS
`define GBN_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBN_ASSERT(label, cond, msg)
`define GBN_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/gbn_pkg.sv -----
package gbn_pkg;

	localparam int SEQ_WIDTH  = 16;
	localparam int WS_WIDTH   = 7;
	localparam int PC_WIDTH   = 16;
	localparam int FUNC_WIDTH = 2;
	localparam int ACK_WIDTH  = 16;

	localparam int PADDR_WIDTH = 3;
	localparam int PDATA_WIDTH = 32;

	localparam logic [WS_WIDTH-1:0] WS_MAX   = WS_WIDTH'(64);
	localparam logic [WS_WIDTH-1:0] WS_RESET = WS_WIDTH'(2);
	localparam logic [PC_WIDTH-1:0] PC_RESET = PC_WIDTH'(5);

	localparam logic [FUNC_WIDTH-1:0] FUNC_START   = 2'd0;
	localparam logic [FUNC_WIDTH-1:0] FUNC_TIMEOUT = 2'd1;
	localparam logic [FUNC_WIDTH-1:0] FUNC_ACK     = 2'd2;

	localparam logic REG_WINDOW_SIZE  = 1'b0;
	localparam logic REG_PACKET_COUNT = 1'b1;

	// Largest sequence number that fits, held wide enough for any SEQ_WIDTH up to 32.
	localparam logic [32:0] SEQ_MAX = (33'd1 << SEQ_WIDTH) - 33'd1;

	typedef logic [SEQ_WIDTH-1:0] seq_t;
	typedef logic [SEQ_WIDTH:0]   seq_wide_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last;
	} dp_status_t;

	// Window size with zero read as one and anything above the limit clipped.
	function automatic logic [WS_WIDTH-1:0] eff_window(input logic [WS_WIDTH-1:0] ws);
		logic [WS_WIDTH-1:0] r;
		r = ws;
		if (ws == '0) begin
			r = WS_WIDTH'(1);
		end else if (ws > WS_MAX) begin
			r = WS_MAX;
		end
		return r;
	endfunction

	// Packet count clipped to the largest sequence number.
	function automatic seq_t eff_count(input logic [PC_WIDTH-1:0] pc);
		seq_t r;
		if (33'(pc) > SEQ_MAX) begin
			r = seq_t'(SEQ_MAX);
		end else begin
			r = seq_t'(pc);
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/gbn_if.sv -----
interface gbn_event_if import gbn_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FUNC_WIDTH-1:0] func;
	logic [ACK_WIDTH-1:0]  ack_number;

	modport source (output valid, output func, output ack_number, input ready);
	modport sink (input valid, input func, input ack_number, output ready);
endinterface

interface gbn_result_if import gbn_pkg::*; ();
	logic valid;
	logic ready;
	seq_t seq_number;
	logic is_send;
	logic all_acked;
	logic last_of_run;

	modport source (output valid, output seq_number, output is_send, output all_acked,
		output last_of_run, input ready);
	modport sink (input valid, input seq_number, input is_send, input all_acked,
		input last_of_run, output ready);
endinterface

// ----- hw/rtl/go_back_n_sender_window.sv -----
// Go-Back-N sender window. Each event transaction (start, timeout or acknowledgement)
// produces a run of result transactions, the last one flagged by last_of_run. Start
// opens a window of up to window_size sequence numbers, clipped to the packet total; a
// timeout or a mismatching acknowledgement resends every number of the current window;
// the acknowledgement equal to the window base slides the window by one and sends the
// next number if any remain. Acknowledgements are not cumulative. An event that sends
// nothing yields one status transaction (is_send low) carrying the window base, and
// all_acked reports whether the base has reached the packet total after the event.
// An event producing n result transactions (n from 1 to 64) is handled in two steps:
// the block takes the event and updates the window, then passes the results one at a
// time through the single output register while that register has room. The next event
// is taken once the last result of the run has entered that register, so it may overlap
// with the last result waiting downstream. Registers are written through the APB port
// with window_size at byte address 0 and the packet total at byte address 4; writes must
// only occur while no event is in progress.

`include "go_back_n_sender_window_assert.svh"

module go_back_n_sender_window import gbn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	gbn_event_if.sink              event_in,
	gbn_result_if.source           result_out,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_WIDTH-1:0] paddr,
	input  logic [PDATA_WIDTH-1:0] pwdata,
	output logic [PDATA_WIDTH-1:0] prdata,
	output logic                   pready
);

	logic [WS_WIDTH-1:0] window_size_q;
	logic [PC_WIDTH-1:0] pkt_total_q;
	logic                cfg_write;
	logic                reg_sel;
	ctrl_cmd_t           cmd;
	dp_status_t          sts;

	// The configuration port never stalls; a write lands at the end of the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_sel   = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WS_RESET;
			pkt_total_q   <= PC_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				REG_WINDOW_SIZE:  window_size_q <= pwdata[WS_WIDTH-1:0];
				REG_PACKET_COUNT: pkt_total_q   <= pwdata[PC_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WINDOW_SIZE:  prdata = PDATA_WIDTH'(window_size_q);
			REG_PACKET_COUNT: prdata = PDATA_WIDTH'(pkt_total_q);
			default:          prdata = '0;
		endcase
	end

	// The controller sequences one event at a time: it takes the event, then steps the
	// datapath once per result while the output register has room.
	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (event_in.valid),
		.in_ready (event_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the window state, the range still to send and the output register.
	gbn_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.window_size  (window_size_q),
		.pkt_total    (pkt_total_q),
		.func         (event_in.func),
		.ack_number   (event_in.ack_number),
		.out_ready    (result_out.ready),
		.out_valid    (result_out.valid),
		.seq_number   (result_out.seq_number),
		.is_send      (result_out.is_send),
		.all_acked    (result_out.all_acked),
		.last_of_run  (result_out.last_of_run)
	);

	// An accepted event always produces at least one result, so the block must be busy next.
	`GBN_ASSERT_NEXT(a_busy_after_event, event_in.valid && event_in.ready, !event_in.ready, "event accepted but block not busy afterwards")
	// A status transaction is only ever the sole, and thus last, item of its run.
	`GBN_ASSERT(a_status_is_last, !result_out.valid || result_out.is_send || result_out.last_of_run, "status transaction not marked last of run")
	// Once every packet is acknowledged nothing is left to transmit.
	`GBN_ASSERT(a_done_sends_nothing, !(result_out.valid && result_out.all_acked && result_out.is_send), "transmit transaction reported after completion")

endmodule

// ----- hw/rtl/gbn_dpath.sv -----
module gbn_dpath import gbn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            sts,
	input  logic [WS_WIDTH-1:0]   window_size,
	input  logic [PC_WIDTH-1:0]   pkt_total,
	input  logic [FUNC_WIDTH-1:0] func,
	input  logic [ACK_WIDTH-1:0]  ack_number,
	input  logic                  out_ready,
	output logic                  out_valid,
	output seq_t                  seq_number,
	output logic                  is_send,
	output logic                  all_acked,
	output logic                  last_of_run
);

	seq_t base_q;
	seq_t limit_q;
	seq_t cur_q;
	seq_t end_q;
	logic done_q;
	logic out_valid_q;
	seq_t seq_q;
	logic send_q;
	logic done_out_q;
	logic last_q;

	logic [WS_WIDTH-1:0] ws_e;
	seq_t                pc_e;
	logic                active;
	logic                ack_hit;
	seq_t                nb;
	seq_t                nl;
	seq_t                ncur;
	seq_t                nend;
	seq_t                lim1;
	seq_t                lim_pc;
	seq_wide_t           span_end;
	logic                sending;
	logic                item_last;

	always_comb begin
		ws_e     = eff_window(window_size);
		pc_e     = eff_count(pkt_total);
		active   = (func == FUNC_TIMEOUT || func == FUNC_ACK) && (base_q < pc_e);
		ack_hit  = (func == FUNC_ACK) && (33'(ack_number) == 33'(base_q));
		nb       = base_q;
		nl       = limit_q;
		ncur     = base_q;
		nend     = base_q;
		lim1     = limit_q;
		lim_pc   = (limit_q < pc_e) ? limit_q : pc_e;
		span_end = {1'b0, base_q} + (SEQ_WIDTH+1)'(ws_e);
		priority if (func == FUNC_START) begin
			nb   = '0;
			nl   = ((SEQ_WIDTH+1)'(ws_e) < {1'b0, pc_e}) ? seq_t'(ws_e) : pc_e;
			ncur = '0;
			nend = nl;
		end else if (active && ack_hit) begin
			nb   = base_q + seq_t'(1);
			lim1 = (limit_q < nb) ? nb : limit_q;
			nl   = lim1;
			ncur = nb;
			nend = nb;
			if (lim1 < pc_e) begin
				ncur = lim1;
				nend = lim1 + seq_t'(1);
				nl   = lim1 + seq_t'(1);
			end
		end else if (active) begin
			ncur = base_q;
			nend = ({1'b0, lim_pc} < span_end) ? lim_pc : seq_t'(span_end);
		end else begin
			ncur = base_q;
			nend = base_q;
		end
	end

	// An empty range yields the single status item of the event.
	assign sending   = cur_q < end_q;
	assign item_last = !sending || ((cur_q + seq_t'(1)) == end_q);

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last     = item_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				base_q  <= nb;
				limit_q <= nl;
			end
			if (cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q  <= ncur;
			end_q  <= nend;
			done_q <= (nb >= pc_e);
		end else if (cmd.step && sending) begin
			cur_q <= cur_q + seq_t'(1);
		end
		if (cmd.step) begin
			seq_q      <= sending ? cur_q : base_q;
			send_q     <= sending;
			done_out_q <= done_q;
			last_q     <= item_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign seq_number  = seq_q;
	assign is_send     = send_q;
	assign all_acked   = done_out_q;
	assign last_of_run = last_q;

endmodule

// ----- hw/rtl/gbn_ctrl.sv -----
module gbn_ctrl import gbn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;

	assign in_ready = (state_q == ST_IDLE);
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.step = (state_q == ST_EMIT) && sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.step && sts.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- tb/go_back_n_sender_window_test.sv -----
`timescale 1ns / 100ps

// Testbench for the Go-Back-N sender window.
module go_back_n_sender_window_test import gbn_pkg::*; ();

	// Event code the block must ignore. It still answers with a single status transaction.
	localparam logic [FUNC_WIDTH-1:0] FUNC_UNUSED = 2'd3;

	// Hard stop for the run. The slowest correct run stays well below this.
	localparam int CYCLE_LIMIT = 400000;

	// Cycles allowed after the last expected result, so that stray results still show up.
	localparam int TAIL_CYCLES = 20;

	// Mirror of the sender window. It holds its own copy of both registers and of the
	// window, works out the result transactions that each accepted event must give, and
	// checks the results as they leave the block.
	class send_window_tracker;
		typedef struct {
			seq_t seq;
			logic is_send;
			logic all_acked;
			logic last_of_run;
		} xmit_t;

		logic [WS_WIDTH-1:0] ws_reg;
		logic [PC_WIDTH-1:0] pc_reg;
		int unsigned win_base;
		int unsigned win_limit;
		xmit_t awaited[$];
		int mismatches;

		function new();
			ws_reg = WS_RESET;
			pc_reg = PC_RESET;
			win_base = 0;
			win_limit = 0;
			mismatches = 0;
		endfunction

		function void report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		function void write_reg(logic idx, logic [PDATA_WIDTH-1:0] value);
			if (idx == REG_WINDOW_SIZE) begin
				ws_reg = value[WS_WIDTH-1:0];
			end else begin
				pc_reg = value[PC_WIDTH-1:0];
			end
		endfunction

		function logic [PDATA_WIDTH-1:0] reg_value(logic idx);
			if (idx == REG_WINDOW_SIZE) begin
				return PDATA_WIDTH'(ws_reg);
			end
			return PDATA_WIDTH'(pc_reg);
		endfunction

		// Packet count as the window sees it: it cannot pass the largest sequence number.
		function int unsigned pc_limit();
			longint unsigned top;
			top = (64'd1 << SEQ_WIDTH) - 64'd1;
			return (pc_reg > top) ? int'(top) : int'(pc_reg);
		endfunction

		// Window size as the window sees it: zero means one, anything past the maximum clips.
		function int unsigned ws_limit();
			if (ws_reg == '0) begin
				return 1;
			end
			return (ws_reg > WS_MAX) ? int'(WS_MAX) : int'(ws_reg);
		endfunction

		function bit in_progress();
			return (win_base < pc_limit()) && (win_limit > win_base);
		endfunction

		function void accept_event(logic [FUNC_WIDTH-1:0] func, logic [ACK_WIDTH-1:0] ack);
			xmit_t run[$];
			int unsigned pc;
			int unsigned ws;
			int unsigned stop;
			int unsigned s;
			logic done;
			pc = pc_limit();
			ws = ws_limit();
			if (func == FUNC_START) begin
				win_base = 0;
				win_limit = (ws < pc) ? ws : pc;
				for (s = 0; s < win_limit; s++) begin
					run.push_back('{seq_t'(s), 1'b1, 1'b0, 1'b0});
				end
			end else if ((func == FUNC_TIMEOUT || func == FUNC_ACK) && win_base < pc) begin
				if (func == FUNC_ACK && 32'(ack) == win_base) begin
					// The matching acknowledgement slides the window by one.
					win_base = (win_base + 1) & ((1 << SEQ_WIDTH) - 1);
					if (win_limit < win_base) begin
						win_limit = win_base;
					end
					if (win_limit < pc) begin
						run.push_back('{seq_t'(win_limit), 1'b1, 1'b0, 1'b0});
						win_limit = (win_limit + 1) & ((1 << SEQ_WIDTH) - 1);
					end
				end else begin
					// Go back: resend the whole window, clipped by the current registers.
					stop = (win_limit < pc) ? win_limit : pc;
					if (win_base + ws < stop) begin
						stop = win_base + ws;
					end
					for (s = win_base; s < stop; s++) begin
						run.push_back('{seq_t'(s), 1'b1, 1'b0, 1'b0});
					end
				end
			end
			if (run.size() == 0) begin
				run.push_back('{seq_t'(win_base), 1'b0, 1'b0, 1'b0});
			end
			done = (win_base >= pc);
			foreach (run[i]) begin
				run[i].all_acked = done;
				run[i].last_of_run = (i == run.size() - 1);
				awaited.push_back(run[i]);
			end
		endfunction

		function void check_item(seq_t seq, logic is_send, logic all_acked, logic last_of_run);
			xmit_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result seq_number=%0d with nothing expected", seq));
				return;
			end
			want = awaited.pop_front();
			if (seq !== want.seq) begin
				report($sformatf("seq_number %0d, expected %0d", seq, want.seq));
			end
			if (is_send !== want.is_send) begin
				report($sformatf("is_send %b, expected %b (seq %0d)", is_send, want.is_send,
					want.seq));
			end
			if (all_acked !== want.all_acked) begin
				report($sformatf("all_acked %b, expected %b (seq %0d)", all_acked,
					want.all_acked, want.seq));
			end
			if (last_of_run !== want.last_of_run) begin
				report($sformatf("last_of_run %b, expected %b (seq %0d)", last_of_run,
					want.last_of_run, want.seq));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [PADDR_WIDTH-1:0] paddr;
	logic [PDATA_WIDTH-1:0] pwdata;
	logic [PDATA_WIDTH-1:0] prdata;
	logic                   pready;

	gbn_event_if  evt_if ();
	gbn_result_if res_if ();

	send_window_tracker tracker;

	// Idle chances in percent per cycle, and the length of a forced receiver hold-off.
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_left;
	int cycle_count;

	go_back_n_sender_window dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.event_in  (evt_if),
		.result_out(res_if),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle counter. If the run is still going at the limit, something has hung.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL go_back_n_sender_window");
		$finish;
	end

	// Result sink. It drops ready at random, or for a whole forced hold-off, which it
	// counts down here in its own process while the sender keeps offering events.
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Every result transaction is checked against the oldest expectation at the edge
	// where it is accepted.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			tracker.check_item(res_if.seq_number, res_if.is_send, res_if.all_acked,
				res_if.last_of_run);
		end
	end

	// Offers one event transaction. It is called at a falling edge and returns at the
	// falling edge after the transaction was accepted. Valid stays high from one event to
	// the next unless the sender decides to idle.
	task automatic offer_event(input logic [FUNC_WIDTH-1:0] f, input logic [ACK_WIDTH-1:0] a);
		while ($urandom_range(99) < tx_idle_pct) begin
			evt_if.valid <= 1'b0;
			@(negedge clk);
		end
		evt_if.valid <= 1'b1;
		evt_if.func <= f;
		evt_if.ack_number <= a;
		do @(posedge clk); while (!evt_if.ready);
		tracker.accept_event(f, a);
		@(negedge clk);
	endtask

	// Stops offering and waits for every expected result. It always waits for a falling
	// edge first, so valid is never lowered and raised in the same step.
	task automatic drain_results();
		evt_if.valid <= 1'b0;
		do @(negedge clk); while (tracker.awaited.size() != 0);
	endtask

	// APB write followed by a read-back of the same register.
	task automatic program_reg(input logic idx, input logic [PDATA_WIDTH-1:0] value);
		logic [PDATA_WIDTH-1:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_WIDTH'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, value);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== tracker.reg_value(idx)) begin
			tracker.report($sformatf("register %0d reads %0h, expected %0h", idx, got,
				tracker.reg_value(idx)));
		end
	endtask

	// Registers only change while the block is idle: every result is out, and a further
	// wait on falling edges lets the output register empty.
	task automatic set_window(input int unsigned ws, input int unsigned pc);
		drain_results();
		repeat (4) @(negedge clk);
		program_reg(REG_WINDOW_SIZE, PDATA_WIDTH'(ws));
		program_reg(REG_PACKET_COUNT, PDATA_WIDTH'(pc));
	endtask

	// Picks the next random event. While a transfer is running, most events are the
	// acknowledgement that the window waits for, so transfers get through to the end.
	// The rest are timeouts, stale or wild acknowledgements, restarts and unused codes.
	task automatic pick_event(output logic [FUNC_WIDTH-1:0] f, output logic [ACK_WIDTH-1:0] a);
		int r;
		r = $urandom_range(99);
		a = ACK_WIDTH'($urandom);
		if (!tracker.in_progress()) begin
			if (r < 80) begin
				f = FUNC_START;
			end else if (r < 88) begin
				f = FUNC_TIMEOUT;
			end else if (r < 95) begin
				f = FUNC_ACK;
			end else begin
				f = FUNC_UNUSED;
			end
		end else if (r < 65) begin
			f = FUNC_ACK;
			a = ACK_WIDTH'(tracker.win_base);
		end else if (r < 75) begin
			f = FUNC_ACK;
			a = ACK_WIDTH'(tracker.win_base +
				$urandom_range(tracker.win_limit - tracker.win_base - 1));
		end else if (r < 85) begin
			f = FUNC_TIMEOUT;
		end else if (r < 90) begin
			f = FUNC_ACK;
		end else if (r < 94) begin
			f = FUNC_UNUSED;
		end else if (r < 97) begin
			f = FUNC_ACK;
			a = ACK_WIDTH'(tracker.win_base - 1);
		end else begin
			f = FUNC_START;
		end
	endtask

	// Random register settings: mostly small transfers that run to completion, with the
	// odd extreme size or count mixed in.
	task automatic random_window();
		int unsigned ws;
		int unsigned pc;
		int r;
		case ($urandom_range(5))
			0: ws = 1;
			1: ws = 64;
			2: ws = 0;
			3: ws = 127;
			default: ws = $urandom_range(2, 8);
		endcase
		r = $urandom_range(99);
		if (r < 8) begin
			pc = 65535;
		end else if (r < 13) begin
			pc = 0;
		end else begin
			pc = $urandom_range(1, 40);
		end
		set_window(ws, pc);
	endtask

	// A block of random events. Halfway through, the sender waits for every result.
	task automatic random_block(input int count);
		logic [FUNC_WIDTH-1:0] f;
		logic [ACK_WIDTH-1:0] a;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				drain_results();
			end
			pick_event(f, a);
			offer_event(f, a);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		evt_if.valid = 1'b0;
		evt_if.func = FUNC_START;
		evt_if.ack_number = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 38;
		rx_idle_pct = 52;
		hold_left = 0;
		tracker = new();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part on the reset registers (window 2, five packets). Events before
		// any start work on the empty reset window.
		offer_event(FUNC_TIMEOUT, 16'd0);
		offer_event(FUNC_ACK, 16'd0);
		offer_event(FUNC_UNUSED, 16'hFFFF);
		offer_event(FUNC_START, 16'd0);
		offer_event(FUNC_ACK, 16'd1);
		offer_event(FUNC_ACK, 16'd0);
		offer_event(FUNC_TIMEOUT, 16'd0);
		offer_event(FUNC_ACK, 16'd1);
		offer_event(FUNC_ACK, 16'd2);
		offer_event(FUNC_ACK, 16'd3);
		offer_event(FUNC_ACK, 16'd4);
		// Transfer done: the timeout and ack 5 only report status, then a restart and a resend.
		offer_event(FUNC_TIMEOUT, 16'd0);
		offer_event(FUNC_ACK, 16'd5);
		offer_event(FUNC_START, 16'd0);
		offer_event(FUNC_ACK, 16'hFFFF);

		// Largest window and largest count: full 64-packet runs.
		set_window(64, 65535);
		offer_event(FUNC_START, 16'd0);
		offer_event(FUNC_TIMEOUT, 16'd0);
		offer_event(FUNC_ACK, 16'd0);
		offer_event(FUNC_ACK, 16'hAAAA);

		// Zero window acts as one, zero count is done at once.
		set_window(0, 0);
		offer_event(FUNC_START, 16'd0);
		offer_event(FUNC_ACK, 16'd0);

		// Oversized window clipped to the count.
		set_window(127, 3);
		offer_event(FUNC_START, 16'd0);

		// Registers shrink in the middle of a transfer: the resend is clipped by both.
		set_window(1, 2);
		offer_event(FUNC_TIMEOUT, 16'd0);
		offer_event(FUNC_ACK, 16'd0);

		// Random part in three idling modes. The first block of the first mode opens
		// with a long receiver hold-off so the block fills up and stalls its input.
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 52 : 0;
			rx_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 38 : 0;
			for (int blk = 0; blk < 3; blk++) begin
				random_window();
				if (mode == 0 && blk == 0) begin
					hold_left = 600;
				end
				random_block(48);
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (tracker.awaited.size() != 0) begin
			tracker.report($sformatf("%0d expected results never came",
				tracker.awaited.size()));
		end
		if (tracker.mismatches == 0) begin
			$display("PASS go_back_n_sender_window");
		end else begin
			$display("FAIL go_back_n_sender_window");
		end
		$finish;
	end

endmodule
